// ===== hw/rtl/dplf_pkg.sv =====
// Shared constants, codes and types of the demand-paging frame manager.
`timescale 1ns / 1ps
package dplf_pkg;

  localparam int NUM_FRAMES = 64;
  localparam int FRAME_W    = $clog2(NUM_FRAMES);
  localparam int MAX_PAGES  = 64;
  localparam int PAGE_W     = $clog2(MAX_PAGES);
  localparam int MAX_ALLOCS = 16;
  localparam int SLOT_W     = $clog2(MAX_ALLOCS);
  localparam int COUNT_W    = FRAME_W + 1;
  localparam int CLOCK_W    = 48;
  localparam int HANDLE_W   = 16;
  localparam int SIZE_W     = 24;
  localparam int FSIZE_W    = 17;
  localparam int STAT_W     = 32;

  localparam logic [1:0] REQ_ALLOC   = 2'd0;
  localparam logic [1:0] REQ_ACCESS  = 2'd1;
  localparam logic [1:0] REQ_DEALLOC = 2'd2;

  localparam logic [1:0] ST_DONE    = 2'd0;
  localparam logic [1:0] ST_FAULT   = 2'd1;
  localparam logic [1:0] ST_REFUSED = 2'd2;

  // One entry of the frame table.
  typedef struct packed {
    logic [SLOT_W-1:0]  slot;
    logic [PAGE_W-1:0]  page;
    logic [CLOCK_W-1:0] last_use;
  } frame_word_t;

endpackage

// ===== hw/rtl/dplf_div.sv =====
// Restoring divider, one quotient bit per cycle, for the page count.
`timescale 1ns / 1ps
module dplf_div (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         start,
  input  logic [dplf_pkg::SIZE_W-1:0]  dividend,
  input  logic [dplf_pkg::FSIZE_W-1:0] divisor,
  output logic                         done,
  output logic [dplf_pkg::SIZE_W-1:0]  quotient,
  output logic                         rem_nonzero
);
  import dplf_pkg::*;

  localparam int CNT_W = $clog2(SIZE_W + 1);

  logic [FSIZE_W-1:0] rem;
  logic [SIZE_W-1:0]  quo;
  logic [FSIZE_W-1:0] dvs;
  logic [CNT_W-1:0]   cnt;
  logic               running;
  logic [FSIZE_W:0]   trial;
  logic [FSIZE_W:0]   diff;

  assign trial = {rem, quo[SIZE_W-1]};
  assign diff  = trial - {1'b0, dvs};

  always_ff @(posedge clk) begin
    if (rst) begin
      running <= 1'b0;
      done    <= 1'b0;
      cnt     <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        running <= 1'b1;
        cnt     <= CNT_W'(SIZE_W);
      end else if (running) begin
        cnt <= cnt - 1'b1;
        if (cnt == CNT_W'(1)) begin
          running <= 1'b0;
          done    <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quo <= dividend;
      rem <= '0;
      dvs <= divisor;
    end else if (running) begin
      if (trial >= {1'b0, dvs}) begin
        rem <= diff[FSIZE_W-1:0];
        quo <= {quo[SIZE_W-2:0], 1'b1};
      end else begin
        rem <= trial[FSIZE_W-1:0];
        quo <= {quo[SIZE_W-2:0], 1'b0};
      end
    end
  end

  assign quotient    = quo;
  assign rem_nonzero = (rem != '0);

endmodule

// ===== hw/rtl/demand_paging_lru_frames.sv =====
// Top level of the demand-paging frame manager with LRU replacement.
`timescale 1ns / 1ps
// Usage: requests arrive on the s_* stream, one transfer per request, with the
// request kind in s_tuser (0 allocate, 1 access, 2 deallocate). Every request
// gives exactly one result transfer on m_*, with the status in m_tuser.
// The frame size register is written through cfg_wen/cfg_wdata; the user must
// write it only while idle, as the block itself does not enforce it. The block
// works on one request at a time. An allocate waits for the bit-serial page-count
// divider. An access fault is served from the free stack while it holds a frame;
// otherwise it evicts the frame found by the LRU scan, which reads the frame table
// one frame per cycle. A deallocate walks each page of the allocation through the
// page table and frame table read ports.
// Residency is not stored per page: a page is resident when the frame its
// page-table entry names is busy and records that same slot and page. So the
// page table needs no clearing and the block is ready right after reset.
// Reset empties the slot table, frees all frames and zeroes the counters.
// A finished result sits in the output register. While the receiver stalls,
// the block still accepts and works out one more request, then holds that
// result and takes no further request until the waiting one has been transferred.
module demand_paging_lru_frames (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_wen,
  input  logic [16:0] cfg_wdata,   // frame_size
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [47:0] s_tdata,     // alloc_size[23:0], handle[39:24], page_index[45:40]
  input  logic [1:0]  s_tuser,     // req_type
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [119:0] m_tdata,    // new_handle, frame, evicted, victim_handle,
                                   // victim_page, paged_in_total, paged_out_total,
                                   // frames_used
  output logic [1:0]  m_tuser      // status
);
  import dplf_pkg::*;

  localparam logic [3:0] S_IDLE     = 4'd0;
  localparam logic [3:0] S_DIV      = 4'd1;
  localparam logic [3:0] S_LOOK     = 4'd2;
  localparam logic [3:0] S_ACC_ENT  = 4'd3;
  localparam logic [3:0] S_ACC_FR   = 4'd4;
  localparam logic [3:0] S_ACC_POP  = 4'd5;
  localparam logic [3:0] S_SCAN     = 4'd6;
  localparam logic [3:0] S_EVICT    = 4'd7;
  localparam logic [3:0] S_FILL     = 4'd8;
  localparam logic [3:0] S_DEA_NEXT = 4'd9;
  localparam logic [3:0] S_DEA_ENT  = 4'd10;
  localparam logic [3:0] S_DEA_FR   = 4'd11;
  localparam logic [3:0] S_OUT      = 4'd12;

  localparam int ENT_AW = SLOT_W + PAGE_W;

  logic [3:0] state;
  logic [FSIZE_W-1:0] frame_size;

  // Request captured at the input transfer.
  logic [1:0]          req;
  logic [HANDLE_W-1:0] hndl_q;
  logic [PAGE_W-1:0]   page_q;

  // Slot table in flip-flops.
  logic [MAX_ALLOCS-1:0] slot_live;
  logic [HANDLE_W-1:0]   slot_handle [MAX_ALLOCS];
  logic [COUNT_W-1:0]    slot_pages  [MAX_ALLOCS];

  logic [FRAME_W-1:0]    frame_busy_idx;
  logic [NUM_FRAMES-1:0] frame_busy;
  logic [COUNT_W-1:0]    free_count;
  logic [HANDLE_W-1:0]   next_id;
  logic [CLOCK_W-1:0]    access_clock;
  logic [STAT_W-1:0]     faults_in;
  logic [STAT_W-1:0]     evictions_out;

  logic [SLOT_W-1:0]  slot_q;
  logic [FRAME_W-1:0] f_q;
  logic [COUNT_W-1:0] idx;
  logic [COUNT_W-1:0] dp;
  logic               best_found;
  logic [FRAME_W-1:0] best_f;
  logic [CLOCK_W-1:0] best_last;
  logic [SLOT_W-1:0]  best_slot;
  logic [PAGE_W-1:0]  best_page;

  // Result being built.
  logic [1:0]          res_status;
  logic [HANDLE_W-1:0] res_new_handle;
  logic [FRAME_W-1:0]  res_frame;
  logic                res_evicted;
  logic [HANDLE_W-1:0] res_vh;
  logic [PAGE_W-1:0]   res_vp;

  // Handle lookup and free-slot search over the slot table.
  logic              hit_found;
  logic [SLOT_W-1:0] hit_slot;
  logic              free_found;
  logic [SLOT_W-1:0] free_slot;

  always_comb begin
    hit_found  = 1'b0;
    hit_slot   = '0;
    free_found = 1'b0;
    free_slot  = '0;
    for (int s = MAX_ALLOCS - 1; s >= 0; s--) begin
      if (slot_live[s] && slot_handle[s] == hndl_q && hndl_q != '0) begin
        hit_found = 1'b1;
        hit_slot  = SLOT_W'(s);
      end
      if (!slot_live[s]) begin
        free_found = 1'b1;
        free_slot  = SLOT_W'(s);
      end
    end
  end

  // Page-count divider.
  logic               div_start;
  logic               div_done;
  logic [SIZE_W-1:0]  div_q;
  logic               div_rnz;
  logic [SIZE_W:0]    pages_full;
  logic               alloc_bad;

  assign div_start = (state == S_IDLE) && s_tvalid && (s_tuser == REQ_ALLOC) &&
                     (frame_size != '0);

  dplf_div u_div (
    .clk         (clk),
    .rst         (rst),
    .start       (div_start),
    .dividend    (s_tdata[SIZE_W-1:0]),
    .divisor     (frame_size),
    .done        (div_done),
    .quotient    (div_q),
    .rem_nonzero (div_rnz)
  );

  assign pages_full = {1'b0, div_q} + {{SIZE_W{1'b0}}, div_rnz};
  assign alloc_bad  = (pages_full == '0) || (pages_full > (SIZE_W+1)'(NUM_FRAMES)) ||
                      (pages_full > (SIZE_W+1)'(MAX_PAGES)) || (next_id == '0) ||
                      !free_found;

  // Page table: frame number of each (slot, page), valid only while the
  // named frame confirms the mapping.
  logic [FRAME_W-1:0] entry_mem [1 << ENT_AW];
  logic [ENT_AW-1:0]  ent_raddr;
  logic [FRAME_W-1:0] ent_rdata;
  logic               ent_we;

  assign ent_raddr = (state == S_DEA_NEXT) ? {slot_q, dp[PAGE_W-1:0]} : {hit_slot, page_q};
  assign ent_we    = (state == S_FILL);

  always_ff @(posedge clk) begin
    if (ent_we) begin
      entry_mem[{slot_q, page_q}] <= f_q;
    end
    ent_rdata <= entry_mem[ent_raddr];
  end

  // Frame table: owner and last use of each frame.
  frame_word_t        frame_mem [NUM_FRAMES];
  logic [FRAME_W-1:0] fr_raddr;
  frame_word_t        fr_rdata;
  frame_word_t        fr_wdata;
  logic               fr_we;
  logic               acc_hit;

  always_comb begin
    case (state)
      S_ACC_ENT, S_DEA_ENT: fr_raddr = ent_rdata;
      S_SCAN:               fr_raddr = idx[FRAME_W-1:0] + 1'b1;
      default:              fr_raddr = '0;
    endcase
  end

  assign acc_hit  = frame_busy[f_q] && (fr_rdata.slot == slot_q) && (fr_rdata.page == page_q);
  assign fr_we    = ((state == S_ACC_FR) && acc_hit) || (state == S_FILL);
  assign fr_wdata = '{slot: slot_q, page: page_q, last_use: access_clock};

  always_ff @(posedge clk) begin
    if (fr_we) begin
      frame_mem[f_q] <= fr_wdata;
    end
    fr_rdata <= frame_mem[fr_raddr];
  end

  // Free-frame stack; an entry never pushed holds its own index.
  logic [FRAME_W-1:0]    stack_mem [NUM_FRAMES];
  logic [NUM_FRAMES-1:0] stack_vld;
  logic [FRAME_W-1:0]    stk_raddr;
  logic [FRAME_W-1:0]    stk_raddr_q;
  logic [FRAME_W-1:0]    stk_rdata;
  logic                  stk_rvld;
  logic                  stk_we;
  logic [FRAME_W-1:0]    stk_value;

  assign stk_raddr = FRAME_W'(free_count - 1'b1);
  assign stk_we    = (state == S_DEA_FR) && frame_busy[f_q] && (fr_rdata.slot == slot_q) &&
                     (fr_rdata.page == dp[PAGE_W-1:0]) &&
                     (free_count < COUNT_W'(NUM_FRAMES));
  assign stk_value = stk_rvld ? stk_rdata : stk_raddr_q;

  always_ff @(posedge clk) begin
    if (stk_we) begin
      stack_mem[free_count[FRAME_W-1:0]] <= f_q;
    end
    stk_rdata   <= stack_mem[stk_raddr];
    stk_raddr_q <= stk_raddr;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      stack_vld <= '0;
      stk_rvld  <= 1'b0;
    end else begin
      if (stk_we) begin
        stack_vld[free_count[FRAME_W-1:0]] <= 1'b1;
      end
      stk_rvld <= stack_vld[stk_raddr];
    end
  end

  // A candidate in the LRU scan: lowest last use, lowest index on ties.
  logic scan_take;
  assign frame_busy_idx = idx[FRAME_W-1:0];
  assign scan_take = frame_busy[frame_busy_idx] &&
                     (!best_found || fr_rdata.last_use < best_last);

  assign s_tready = (state == S_IDLE);

  // Control sequencer.
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      frame_size    <= FSIZE_W'(16);
      slot_live     <= '0;
      frame_busy    <= '0;
      free_count    <= COUNT_W'(NUM_FRAMES);
      next_id       <= HANDLE_W'(1);
      access_clock  <= '0;
      faults_in     <= '0;
      evictions_out <= '0;
      m_tvalid      <= 1'b0;
      for (int s = 0; s < MAX_ALLOCS; s++) begin
        slot_handle[s] <= '0;
        slot_pages[s]  <= '0;
      end
    end else begin
      if (cfg_wen) begin
        frame_size <= cfg_wdata;
      end
      // The result state sets the valid flag itself when it hands over.
      if (m_tvalid && m_tready && (state != S_OUT)) begin
        m_tvalid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (s_tvalid) begin
            req            <= s_tuser;
            hndl_q         <= s_tdata[39:24];
            page_q         <= s_tdata[45:40];
            res_status     <= ST_DONE;
            res_new_handle <= '0;
            res_frame      <= '0;
            res_evicted    <= 1'b0;
            res_vh         <= '0;
            res_vp         <= '0;
            case (s_tuser)
              REQ_ALLOC: begin
                if (frame_size == '0) begin
                  res_status <= ST_REFUSED;
                  state      <= S_OUT;
                end else begin
                  state <= S_DIV;
                end
              end
              REQ_ACCESS: begin
                access_clock <= access_clock + 1'b1;
                state        <= S_LOOK;
              end
              REQ_DEALLOC: begin
                state <= S_LOOK;
              end
              default: begin
                res_status <= ST_REFUSED;
                state      <= S_OUT;
              end
            endcase
          end
        end
        S_DIV: begin
          if (div_done) begin
            if (alloc_bad) begin
              res_status <= ST_REFUSED;
            end else begin
              slot_live[free_slot]   <= 1'b1;
              slot_handle[free_slot] <= next_id;
              slot_pages[free_slot]  <= pages_full[COUNT_W-1:0];
              res_new_handle         <= next_id;
              next_id                <= next_id + 1'b1;
            end
            state <= S_OUT;
          end
        end
        S_LOOK: begin
          slot_q <= hit_slot;
          dp     <= '0;
          if (!hit_found) begin
            res_status <= ST_REFUSED;
            state      <= S_OUT;
          end else if (req == REQ_DEALLOC) begin
            state <= S_DEA_NEXT;
          end else if ({1'b0, page_q} >= slot_pages[hit_slot]) begin
            res_status <= ST_REFUSED;
            state      <= S_OUT;
          end else begin
            state <= S_ACC_ENT;
          end
        end
        S_ACC_ENT: begin
          f_q   <= ent_rdata;
          state <= S_ACC_FR;
        end
        S_ACC_FR: begin
          if (acc_hit) begin
            res_frame <= f_q;
            state     <= S_OUT;
          end else if (free_count != '0) begin
            state <= S_ACC_POP;
          end else begin
            idx        <= '0;
            best_found <= 1'b0;
            best_f     <= '0;
            state      <= S_SCAN;
          end
        end
        S_ACC_POP: begin
          f_q        <= stk_value;
          free_count <= free_count - 1'b1;
          state      <= S_FILL;
        end
        S_SCAN: begin
          if (scan_take) begin
            best_found <= 1'b1;
            best_f     <= idx[FRAME_W-1:0];
            best_last  <= fr_rdata.last_use;
            best_slot  <= fr_rdata.slot;
            best_page  <= fr_rdata.page;
          end
          idx <= idx + 1'b1;
          if (idx == COUNT_W'(NUM_FRAMES - 1)) begin
            state <= S_EVICT;
          end
        end
        S_EVICT: begin
          f_q         <= best_f;
          res_evicted <= 1'b1;
          res_vh      <= slot_handle[best_slot];
          res_vp      <= best_page;
          if (evictions_out != '1) begin
            evictions_out <= evictions_out + 1'b1;
          end
          state <= S_FILL;
        end
        S_FILL: begin
          frame_busy[f_q] <= 1'b1;
          if (faults_in != '1) begin
            faults_in <= faults_in + 1'b1;
          end
          res_status <= ST_FAULT;
          res_frame  <= f_q;
          state      <= S_OUT;
        end
        S_DEA_NEXT: begin
          if (dp >= slot_pages[slot_q]) begin
            slot_live[slot_q] <= 1'b0;
            state             <= S_OUT;
          end else begin
            state <= S_DEA_ENT;
          end
        end
        S_DEA_ENT: begin
          f_q   <= ent_rdata;
          state <= S_DEA_FR;
        end
        S_DEA_FR: begin
          if (frame_busy[f_q] && (fr_rdata.slot == slot_q) &&
              (fr_rdata.page == dp[PAGE_W-1:0])) begin
            frame_busy[f_q] <= 1'b0;
            if (free_count < COUNT_W'(NUM_FRAMES)) begin
              free_count <= free_count + 1'b1;
            end
          end
          dp    <= dp + 1'b1;
          state <= S_DEA_NEXT;
        end
        S_OUT: begin
          if (!m_tvalid || m_tready) begin
            m_tvalid <= 1'b1;
            m_tuser  <= res_status;
            m_tdata  <= {4'b0,
                         COUNT_W'(COUNT_W'(NUM_FRAMES) - free_count),
                         evictions_out, faults_in, res_vp, res_vh,
                         res_evicted, res_frame, res_new_handle};
            state    <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

// ===== bench/tb.sv =====
// Self-checking testbench for the demand-paging frame manager with LRU replacement.
`timescale 1ns / 1ps
module tb;
  import dplf_pkg::*;

  // Expected contents of one result transfer.
  typedef struct {
    logic [1:0]  status;
    logic [15:0] new_handle;
    logic [5:0]  frame;
    logic        evicted;
    logic [15:0] victim_handle;
    logic [5:0]  victim_page;
    logic [31:0] paged_in;
    logic [31:0] paged_out;
    logic [6:0]  used;
  } paging_result_t;

  // One row of the directed table. When has_status is set, the status column is
  // taken as the expected status instead of the predicted one.
  typedef struct {
    logic [1:0]  req;
    logic [23:0] size;
    logic [15:0] hdl;
    logic [5:0]  page;
    bit          has_status;
    logic [1:0]  status;
  } dir_row_t;

  localparam logic [1:0] REQ_UNUSED = 2'd3;
  localparam int LIMIT_CYCLES = 2000000;
  localparam int DRAIN_CYCLES = 200;
  localparam int DIR_ROWS = 15;

  logic         clk = 1'b0;
  logic         rst = 1'b1;
  logic         cfg_wen = 1'b0;
  logic [16:0]  cfg_wdata = '0;
  logic         s_tvalid = 1'b0;
  logic         s_tready;
  logic [47:0]  s_tdata = '0;
  logic [1:0]   s_tuser = '0;
  logic         m_tvalid;
  logic         m_tready = 1'b0;
  logic [119:0] m_tdata;
  logic [1:0]   m_tuser;

  demand_paging_lru_frames dut (
    .clk(clk), .rst(rst),
    .cfg_wen(cfg_wen), .cfg_wdata(cfg_wdata),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser)
  );

  always #2 clk = ~clk;

  // Mirror of the block's state, kept by the predictor.
  logic        slot_live_m [MAX_ALLOCS];
  logic [15:0] slot_hdl_m [MAX_ALLOCS];
  logic [6:0]  slot_npages_m [MAX_ALLOCS];
  logic        page_res_m [MAX_ALLOCS*MAX_PAGES];
  logic [5:0]  page_frm_m [MAX_ALLOCS*MAX_PAGES];
  logic        frm_busy_m [NUM_FRAMES];
  logic [3:0]  frm_slot_m [NUM_FRAMES];
  logic [5:0]  frm_page_m [NUM_FRAMES];
  logic [47:0] frm_used_m [NUM_FRAMES];
  logic [5:0]  free_stk_m [NUM_FRAMES];
  int          free_cnt_m;
  logic [15:0] next_hdl_m;
  logic [47:0] tick_m;
  logic [31:0] faults_m;
  logic [31:0] evicts_m;
  logic [16:0] fsize_m;

  paging_result_t pending_results[$];
  int  errors = 0;
  int  cycles = 0;
  bit  quiet = 1'b0;      // no idling on either side
  bit  press_go = 1'b0;   // asks the receiver for one long hold-off

  task automatic report(input string what, input logic [63:0] got, input logic [63:0] want);
    $display("mismatch %s: got %0d expected %0d at cycle %0d", what, got, want, cycles);
    errors++;
  endtask

  function automatic void clear_model();
    for (int s = 0; s < MAX_ALLOCS; s++) begin
      slot_live_m[s] = 0; slot_hdl_m[s] = '0; slot_npages_m[s] = '0;
    end
    for (int e = 0; e < MAX_ALLOCS*MAX_PAGES; e++) begin
      page_res_m[e] = 0; page_frm_m[e] = '0;
    end
    for (int f = 0; f < NUM_FRAMES; f++) begin
      frm_busy_m[f] = 0; frm_slot_m[f] = '0; frm_page_m[f] = '0;
      frm_used_m[f] = '0; free_stk_m[f] = f[5:0];
    end
    free_cnt_m = NUM_FRAMES;
    next_hdl_m = 16'd1;
    tick_m = '0;
    faults_m = '0;
    evicts_m = '0;
    fsize_m = 17'd16;
  endfunction

  function automatic int slot_of(input logic [15:0] h);
    if (h == 16'd0) return -1;
    for (int s = 0; s < MAX_ALLOCS; s++)
      if (slot_live_m[s] && slot_hdl_m[s] == h) return s;
    return -1;
  endfunction

  // Works out the result of one request and advances the mirrored state.
  function automatic paging_result_t predict_paging(input logic [1:0] req,
      input logic [23:0] size, input logic [15:0] h, input logic [5:0] page);
    paging_result_t r;
    longint unsigned npages;
    longint unsigned oldest;
    int s, e, f, vs, free_slot;
    r = '{default: '0};
    if (req == REQ_ALLOC) begin
      r.status = ST_REFUSED;
      free_slot = -1;
      for (int k = MAX_ALLOCS - 1; k >= 0; k--)
        if (!slot_live_m[k]) free_slot = k;
      if (fsize_m != 0) begin
        npages = (longint'(size) + fsize_m - 1) / fsize_m;
        if (npages != 0 && npages <= NUM_FRAMES && npages <= MAX_PAGES &&
            next_hdl_m != 0 && free_slot >= 0) begin
          slot_live_m[free_slot] = 1;
          slot_hdl_m[free_slot] = next_hdl_m;
          slot_npages_m[free_slot] = npages[6:0];
          for (int p = 0; p < MAX_PAGES; p++) page_res_m[free_slot*MAX_PAGES + p] = 0;
          r.status = ST_DONE;
          r.new_handle = next_hdl_m;
          next_hdl_m = next_hdl_m + 16'd1;
        end
      end
    end else if (req == REQ_ACCESS) begin
      tick_m = tick_m + 48'd1;
      s = slot_of(h);
      if (s < 0 || page >= slot_npages_m[s]) begin
        r.status = ST_REFUSED;
      end else begin
        e = s*MAX_PAGES + page;
        if (page_res_m[e]) begin
          f = page_frm_m[e];
          frm_used_m[f] = tick_m;
          r.status = ST_DONE;
          r.frame = f[5:0];
        end else begin
          if (free_cnt_m > 0) begin
            free_cnt_m--;
            f = free_stk_m[free_cnt_m];
          end else begin
            // Oldest last use wins; the strict compare keeps the lowest index on ties.
            oldest = '1;
            f = 0;
            for (int i = 0; i < NUM_FRAMES; i++)
              if (frm_busy_m[i] && frm_used_m[i] < oldest) begin
                oldest = frm_used_m[i];
                f = i;
              end
            vs = frm_slot_m[f];
            page_res_m[vs*MAX_PAGES + frm_page_m[f]] = 0;
            if (evicts_m != '1) evicts_m++;
            r.evicted = 1'b1;
            r.victim_handle = slot_hdl_m[vs];
            r.victim_page = frm_page_m[f];
          end
          page_res_m[e] = 1;
          page_frm_m[e] = f[5:0];
          frm_busy_m[f] = 1;
          frm_slot_m[f] = s[3:0];
          frm_page_m[f] = page;
          frm_used_m[f] = tick_m;
          if (faults_m != '1) faults_m++;
          r.status = ST_FAULT;
          r.frame = f[5:0];
        end
      end
    end else if (req == REQ_DEALLOC) begin
      s = slot_of(h);
      if (s < 0) begin
        r.status = ST_REFUSED;
      end else begin
        for (int p = 0; p < slot_npages_m[s] && p < MAX_PAGES; p++) begin
          e = s*MAX_PAGES + p;
          if (page_res_m[e]) begin
            f = page_frm_m[e];
            page_res_m[e] = 0;
            frm_busy_m[f] = 0;
            frm_used_m[f] = '0;
            if (free_cnt_m < NUM_FRAMES) begin
              free_stk_m[free_cnt_m] = f[5:0];
              free_cnt_m++;
            end
          end
        end
        slot_live_m[s] = 0;
        r.status = ST_DONE;
      end
    end else begin
      r.status = ST_REFUSED;
    end
    r.paged_in = faults_m;
    r.paged_out = evicts_m;
    r.used = 7'(NUM_FRAMES - free_cnt_m);
    return r;
  endfunction

  // Offers one request, optionally after a random gap, and waits for its transfer.
  task automatic send_request(input logic [1:0] req, input logic [23:0] size,
      input logic [15:0] h, input logic [5:0] page, input bit has_status,
      input logic [1:0] status);
    paging_result_t r;
    if (!quiet && $urandom_range(0, 3) == 0) begin
      s_tvalid = 1'b0;
      repeat ($urandom_range(1, 14)) @(negedge clk);
    end
    s_tvalid = 1'b1;
    s_tuser = req;
    s_tdata = {2'b00, page, h, size};
    r = predict_paging(req, size, h, page);
    if (has_status) r.status = status;
    pending_results = {pending_results, r};
    do @(posedge clk); while (!s_tready);
    @(negedge clk);
  endtask

  function automatic int pick_live_slot();
    int live[$];
    for (int s = 0; s < MAX_ALLOCS; s++)
      if (slot_live_m[s]) live = {live, s};
    if (live.size() == 0) return -1;
    return live[$urandom_range(0, live.size() - 1)];
  endfunction

  // Mostly well-formed traffic on live allocations, with some noise mixed in.
  task automatic random_traffic(input int n);
    int pick, s, np;
    logic [23:0] size;
    for (int i = 0; i < n; i++) begin
      pick = $urandom_range(0, 99);
      s = pick_live_slot();
      if (pick < 20 || (pick < 88 && s < 0)) begin
        np = ($urandom_range(0, 3) == 0) ? 64 : $urandom_range(1, 16);
        if (fsize_m == 0) size = 24'($urandom);
        else size = 24'((np - 1) * fsize_m + $urandom_range(1, fsize_m));
        send_request(REQ_ALLOC, size, 16'($urandom), 6'($urandom), 0, '0);
      end else if (pick < 80) begin
        send_request(REQ_ACCESS, 24'($urandom), slot_hdl_m[s],
                     6'($urandom_range(0, slot_npages_m[s] - 1)), 0, '0);
      end else if (pick < 88) begin
        send_request(REQ_DEALLOC, 24'($urandom), slot_hdl_m[s], 6'($urandom), 0, '0);
      end else if (pick < 93 && s >= 0) begin
        // Live handle, page anywhere in the field, often out of range.
        send_request(REQ_ACCESS, 24'($urandom), slot_hdl_m[s], 6'($urandom), 0, '0);
      end else begin
        send_request(2'($urandom), 24'($urandom), 16'($urandom), 6'($urandom), 0, '0);
      end
    end
  endtask

  // Waits until every result is in and the block has settled, then writes the register.
  task automatic set_frame_size(input logic [16:0] value);
    s_tvalid = 1'b0;
    wait (pending_results.size() == 0);
    repeat (DRAIN_CYCLES) @(negedge clk);
    cfg_wen = 1'b1;
    cfg_wdata = value;
    @(negedge clk);
    cfg_wen = 1'b0;
    fsize_m = value;
  endtask

  // Receiver: random stall bursts, plus one long hold-off on request.
  initial begin
    @(negedge clk);
    forever begin
      if (press_go) begin
        press_go = 1'b0;
        m_tready = 1'b0;
        repeat (400) @(negedge clk);
      end else if (!quiet && $urandom_range(0, 5) == 0) begin
        m_tready = 1'b0;
        repeat ($urandom_range(1, 14)) @(negedge clk);
      end else begin
        m_tready = 1'b1;
        @(negedge clk);
      end
    end
  end

  // Result checking: each transfer is compared with the oldest expectation.
  always @(posedge clk) begin
    paging_result_t want;
    if (!rst && m_tvalid && m_tready) begin
      if (pending_results.size() == 0) begin
        report("unexpected result", m_tuser, 0);
      end else begin
        want = pending_results.pop_front();
        if (m_tuser != want.status) report("status", m_tuser, want.status);
        if (m_tdata[15:0] != want.new_handle) report("new_handle", m_tdata[15:0], want.new_handle);
        if (m_tdata[21:16] != want.frame) report("frame", m_tdata[21:16], want.frame);
        if (m_tdata[22] != want.evicted) report("evicted", m_tdata[22], want.evicted);
        if (m_tdata[38:23] != want.victim_handle)
          report("victim_handle", m_tdata[38:23], want.victim_handle);
        if (m_tdata[44:39] != want.victim_page)
          report("victim_page", m_tdata[44:39], want.victim_page);
        if (m_tdata[76:45] != want.paged_in) report("paged_in", m_tdata[76:45], want.paged_in);
        if (m_tdata[108:77] != want.paged_out)
          report("paged_out", m_tdata[108:77], want.paged_out);
        if (m_tdata[115:109] != want.used) report("frames_used", m_tdata[115:109], want.used);
      end
    end
  end

  // Run-length guard.
  always @(posedge clk) begin
    cycles++;
    if (cycles > LIMIT_CYCLES) begin
      $display("tb: errors");
      $finish;
    end
  end

  initial begin
    dir_row_t dir_tab [DIR_ROWS];
    // After reset: handles 1 and 2 are the first granted; frame size is 16.
    dir_tab = '{
      '{REQ_ACCESS,  24'd0,        16'd0,     6'd0,  1, ST_REFUSED},  // handle none
      '{REQ_DEALLOC, 24'd0,        16'd5,     6'd0,  1, ST_REFUSED},  // unknown handle
      '{REQ_UNUSED,  24'hFFFFFF,   16'hFFFF,  6'd63, 1, ST_REFUSED},  // unused kind
      '{REQ_ALLOC,   24'd0,        16'd0,     6'd0,  1, ST_REFUSED},  // zero pages
      '{REQ_ALLOC,   24'hFFFFFF,   16'd0,     6'd0,  1, ST_REFUSED},  // far too many
      '{REQ_ALLOC,   24'd1024,     16'd0,     6'd0,  0, ST_DONE},     // exactly 64 pages
      '{REQ_ALLOC,   24'd1025,     16'd0,     6'd0,  1, ST_REFUSED},  // 65 pages
      '{REQ_ALLOC,   24'd1,        16'd0,     6'd0,  0, ST_DONE},     // one page
      '{REQ_ACCESS,  24'd0,        16'd2,     6'd0,  1, ST_FAULT},    // first touch
      '{REQ_ACCESS,  24'd0,        16'd2,     6'd0,  1, ST_DONE},     // hit
      '{REQ_ACCESS,  24'd0,        16'd2,     6'd1,  1, ST_REFUSED},  // page out of range
      '{REQ_ACCESS,  24'd0,        16'd1,     6'd63, 1, ST_FAULT},
      '{REQ_DEALLOC, 24'd0,        16'd1,     6'd0,  1, ST_DONE},
      '{REQ_DEALLOC, 24'd0,        16'd1,     6'd0,  1, ST_REFUSED},  // already gone
      '{REQ_ACCESS,  24'd0,        16'hFFFF,  6'd63, 1, ST_REFUSED}
    };
    clear_model();
    repeat (6) @(negedge clk);
    rst = 1'b0;

    for (int i = 0; i < DIR_ROWS; i++)
      send_request(dir_tab[i].req, dir_tab[i].size, dir_tab[i].hdl, dir_tab[i].page,
                   dir_tab[i].has_status, dir_tab[i].status);

    // A zero frame size refuses every allocate; accesses still go on.
    set_frame_size(17'd0);
    random_traffic(30);

    // Smallest frame size, with the long receiver hold-off early on so the
    // block backs up while requests keep coming.
    set_frame_size(17'd1);
    press_go = 1'b1;
    random_traffic(500);

    set_frame_size(17'd65536);
    random_traffic(450);

    set_frame_size(17'd65535);
    random_traffic(450);

    // Last part runs with no idling on either side.
    set_frame_size(17'd16);
    quiet = 1'b1;
    random_traffic(600);

    s_tvalid = 1'b0;
    wait (pending_results.size() == 0);
    repeat (DRAIN_CYCLES) @(negedge clk);
    if (errors == 0) begin
      $display("tb: clean");
    end else begin
      $display("tb: errors");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
hw/rtl/dplf_pkg.sv
hw/rtl/dplf_div.sv
hw/rtl/demand_paging_lru_frames.sv
bench/tb.sv
